// ===== hdl/vzd_pkg.sv =====
// Package for the varint zig-zag delta decoder: result kinds, error codes,
// phase encoding, result and step structs, queue sizing and the width mask.
// No dependencies.
package vzd_pkg;

  localparam logic [31:0] MAX_OUTPUT_BYTES_DEF = 32'd16777216;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QLW    = QAW + 1;

  localparam logic [1:0] HDR_LAST_BYTE    = 2'd3;
  localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;

  typedef enum logic [1:0] {
    KIND_ELEM = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_SHORT_HDR     = 3'd1,
    ERR_OVER_LIMIT    = 3'd2,
    ERR_SIZE_MISMATCH = 3'd3,
    ERR_VARINT_LONG   = 3'd4,
    ERR_TRUNCATED     = 3'd5
  } err_e;

  typedef enum logic [1:0] {
    REG_SIZE_CODE = 2'd0,
    REG_EXPECTED  = 2'd1
  } reg_e;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_BODY   = 4'b0010,
    PH_DONE   = 4'b0100,
    PH_ERROR  = 4'b1000
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    err_e        code;
    logic [63:0] value;
    logic [31:0] index;
    logic        last;
  } result_t;

  // n results valid, r0 first
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } step_t;

  function automatic logic [63:0] width_mask(input logic [1:0] code);
    logic [63:0] m;
    unique case (code)
      2'd0:    m = 64'h0000_0000_0000_00FF;
      2'd1:    m = 64'h0000_0000_0000_FFFF;
      2'd2:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic result_t mk_result(input kind_e kind, input err_e code,
                                        input logic [63:0] value,
                                        input logic [31:0] index, input logic last);
    result_t r;
    r.kind  = kind;
    r.code  = code;
    r.value = value;
    r.index = index;
    r.last  = last;
    return r;
  endfunction

endpackage

// ===== hdl/varint_zigzag_delta_decoder.sv =====
// Top level of the varint zig-zag delta decoder: stream ports, configuration
// registers, decode core and result queue. Depends on vzd_pkg, vzd_core, vzd_queue.
//
//  channel   | direction | handshake               | payload
//  s_axis    | in        | s_axis_tvalid/tready    | tdata=in_byte, tlast=in_last
//  m_axis    | out       | m_axis_tvalid/tready    | tdata, tuser=result_kind,
//            |           |                         | tlast=run_last
//  cfg       | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One byte per cycle; a byte is decoded in the cycle it is accepted and its
// results land in a four-entry queue, one result leaves per cycle while
// m_axis_tready is high. A byte that yields two results fills two queue entries
// at once; input holds while fewer than two queue entries are free.
// Reset clears block state, queue and configuration; no clearing pass.
module varint_zigzag_delta_decoder #(
  parameter logic [31:0] MAX_OUTPUT_BYTES = vzd_pkg::MAX_OUTPUT_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] in_byte
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // [2:0] error_code, [66:3] element_value,
                                       // [98:67] element_index, rest zero
  output logic [1:0]   m_axis_tuser,   // [1:0] result_kind
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  logic [1:0]                 size_code_q;
  logic [31:0]                expected_q;
  logic                       accept;
  vzd_pkg::step_t             step;
  vzd_pkg::result_t           head;
  logic [vzd_pkg::QLW-1:0]    level;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_code_q <= 2'd0;
      expected_q  <= 32'd0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == vzd_pkg::REG_SIZE_CODE) begin
        size_code_q <= cfg_data_i[1:0];
      end
      if (cfg_index_i == vzd_pkg::REG_EXPECTED) begin
        expected_q <= cfg_data_i;
      end
    end
  end

  assign s_axis_tready = level <= vzd_pkg::QLW'(vzd_pkg::QDEPTH - 2);
  assign accept        = s_axis_tvalid && s_axis_tready;

  vzd_core #(
    .MAX_OUTPUT_BYTES(MAX_OUTPUT_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .size_code_i (size_code_q),
    .expected_i  (expected_q),
    .step_o      (step)
  );

  vzd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .step_i  (step),
    .pop_i   (m_axis_tready),
    .head_o  (head),
    .level_o (level)
  );

  assign m_axis_tvalid = level != '0;
  assign m_axis_tdata  = {5'b00000, head.index, head.value, head.code};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;

  a_level_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= vzd_pkg::QLW'(vzd_pkg::QDEPTH))
    else $error("result queue overflow");

  a_nonelem_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != vzd_pkg::KIND_ELEM)) |-> m_axis_tlast)
    else $error("end or error result without run_last");

  a_elem_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == vzd_pkg::KIND_ELEM)) |->
      (!m_axis_tlast && (m_axis_tdata[2:0] == vzd_pkg::ERR_NONE)))
    else $error("element result carries run_last or error code");

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (step.n == 2'd2)) |=> (level != '0))
    else $error("double result lost");

endmodule

// ===== hdl/vzd_core.sv =====
// Decode core: per-block state registers and the single-pass step logic that
// turns one accepted byte into zero, one or two results. Depends on vzd_pkg.
module vzd_core #(
  parameter logic [31:0] MAX_OUTPUT_BYTES = vzd_pkg::MAX_OUTPUT_BYTES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      byte_i,
  input  logic            last_i,
  input  logic [1:0]      size_code_i,
  input  logic [31:0]     expected_i,
  output vzd_pkg::step_t  step_o
);

  vzd_pkg::phase_e phase_q, phase_d;
  logic [1:0]  hdr_q, hdr_d;
  logic [31:0] count_q, count_d;
  logic [31:0] done_q, done_d;
  logic [63:0] var_q, var_d;
  logic [3:0]  vbytes_q, vbytes_d;
  logic [63:0] sum_q, sum_d;

  logic [31:0] count_new;
  logic [34:0] size;
  logic        over, mismatch;
  logic [6:0]  shamt7;
  logic [63:0] var_new, mask, zz, sum_new;
  logic [31:0] done_new;
  logic [3:0]  vbytes_new;
  logic        clear;
  vzd_pkg::step_t step;

  assign count_new  = count_q | ({24'b0, byte_i} << {hdr_q, 3'b000});
  assign size       = {3'b000, count_new} << size_code_i;
  assign over       = size > {3'b000, MAX_OUTPUT_BYTES};
  assign mismatch   = (expected_i != 32'd0) && ({3'b000, expected_i} != size);
  assign shamt7     = {vbytes_q, 3'b000} - {3'b000, vbytes_q};
  assign var_new    = var_q | ({57'b0, byte_i[6:0]} << shamt7[5:0]);
  assign mask       = vzd_pkg::width_mask(size_code_i);
  assign zz         = ((var_new >> 1) ^ {64{var_new[0]}}) & mask;
  assign sum_new    = (sum_q + zz) & mask;
  assign done_new   = done_q + 32'd1;
  assign vbytes_new = vbytes_q + 4'd1;

  always_comb begin
    phase_d  = phase_q;
    hdr_d    = hdr_q;
    count_d  = count_q;
    done_d   = done_q;
    var_d    = var_q;
    vbytes_d = vbytes_q;
    sum_d    = sum_q;
    clear    = 1'b0;
    step     = '0;
    unique case (phase_q)
      vzd_pkg::PH_HEADER: begin
        count_d = count_new;
        if (hdr_q != vzd_pkg::HDR_LAST_BYTE) begin
          hdr_d = hdr_q + 2'd1;
          if (last_i) begin
            step.n  = 2'd1;
            step.r0 = vzd_pkg::mk_result(vzd_pkg::KIND_ERR, vzd_pkg::ERR_SHORT_HDR,
                                         64'd0, 32'd0, 1'b1);
            clear   = 1'b1;
          end
        end else begin
          if (over || mismatch) begin
            step.n  = 2'd1;
            step.r0 = vzd_pkg::mk_result(vzd_pkg::KIND_ERR,
                                         over ? vzd_pkg::ERR_OVER_LIMIT
                                              : vzd_pkg::ERR_SIZE_MISMATCH,
                                         64'd0, 32'd0, 1'b1);
            phase_d = vzd_pkg::PH_ERROR;
          end else begin
            phase_d = (count_new == 32'd0) ? vzd_pkg::PH_DONE : vzd_pkg::PH_BODY;
            if (last_i) begin
              step.n  = 2'd1;
              step.r0 = (count_new == 32'd0)
                ? vzd_pkg::mk_result(vzd_pkg::KIND_END, vzd_pkg::ERR_NONE,
                                     64'd0, 32'd0, 1'b1)
                : vzd_pkg::mk_result(vzd_pkg::KIND_ERR, vzd_pkg::ERR_TRUNCATED,
                                     64'd0, 32'd0, 1'b1);
            end
          end
          clear = last_i;
        end
      end
      vzd_pkg::PH_BODY: begin
        if (!byte_i[7]) begin
          step.r0  = vzd_pkg::mk_result(vzd_pkg::KIND_ELEM, vzd_pkg::ERR_NONE,
                                        sum_new, done_q, 1'b0);
          step.n   = 2'd1;
          sum_d    = sum_new;
          done_d   = done_new;
          var_d    = 64'd0;
          vbytes_d = 4'd0;
          if (done_new >= count_q) begin
            phase_d = vzd_pkg::PH_DONE;
          end
          if (last_i) begin
            step.n  = 2'd2;
            step.r1 = (done_new >= count_q)
              ? vzd_pkg::mk_result(vzd_pkg::KIND_END, vzd_pkg::ERR_NONE,
                                   64'd0, 32'd0, 1'b1)
              : vzd_pkg::mk_result(vzd_pkg::KIND_ERR, vzd_pkg::ERR_TRUNCATED,
                                   64'd0, 32'd0, 1'b1);
            clear   = 1'b1;
          end
        end else begin
          var_d    = var_new;
          vbytes_d = vbytes_new;
          if (vbytes_new >= vzd_pkg::VARINT_MAX_BYTES) begin
            step.n  = 2'd1;
            step.r0 = vzd_pkg::mk_result(vzd_pkg::KIND_ERR, vzd_pkg::ERR_VARINT_LONG,
                                         64'd0, 32'd0, 1'b1);
            phase_d = vzd_pkg::PH_ERROR;
            clear   = last_i;
          end else if (last_i) begin
            step.n  = 2'd1;
            step.r0 = vzd_pkg::mk_result(vzd_pkg::KIND_ERR, vzd_pkg::ERR_TRUNCATED,
                                         64'd0, 32'd0, 1'b1);
            clear   = 1'b1;
          end
        end
      end
      vzd_pkg::PH_DONE: begin
        if (last_i) begin
          step.n  = 2'd1;
          step.r0 = vzd_pkg::mk_result(vzd_pkg::KIND_END, vzd_pkg::ERR_NONE,
                                       64'd0, 32'd0, 1'b1);
          clear   = 1'b1;
        end
      end
      default: begin
        clear = last_i;
      end
    endcase
    if (clear) begin
      phase_d  = vzd_pkg::PH_HEADER;
      hdr_d    = 2'd0;
      count_d  = 32'd0;
      done_d   = 32'd0;
      var_d    = 64'd0;
      vbytes_d = 4'd0;
      sum_d    = 64'd0;
    end
  end

  assign step_o = step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= vzd_pkg::PH_HEADER;
      hdr_q    <= 2'd0;
      count_q  <= 32'd0;
      done_q   <= 32'd0;
      var_q    <= 64'd0;
      vbytes_q <= 4'd0;
      sum_q    <= 64'd0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      hdr_q    <= hdr_d;
      count_q  <= count_d;
      done_q   <= done_d;
      var_q    <= var_d;
      vbytes_q <= vbytes_d;
      sum_q    <= sum_d;
    end
  end

endmodule

// ===== hdl/vzd_queue.sv =====
// Result queue: takes up to two results per cycle, hands out one per cycle while
// pop_i is high, from a registered head entry. Depends on vzd_pkg.
module vzd_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  vzd_pkg::step_t              step_i,
  input  logic                        pop_i,
  output vzd_pkg::result_t            head_o,
  output logic [vzd_pkg::QLW-1:0]     level_o
);

  vzd_pkg::result_t             mem_q [vzd_pkg::QDEPTH];
  logic [vzd_pkg::QAW-1:0]      wr_q, wr_d, rd_q, rd_d, wr_next;
  logic [vzd_pkg::QLW-1:0]      level_q, level_d;
  logic [1:0]                   n_push;
  logic                         do_pop;

  assign n_push  = push_i ? step_i.n : 2'd0;
  assign do_pop  = pop_i && (level_q != '0);
  assign wr_next = wr_q + vzd_pkg::QAW'(1);
  assign wr_d    = wr_q + vzd_pkg::QAW'(n_push);
  assign rd_d    = rd_q + vzd_pkg::QAW'(do_pop);
  assign level_d = level_q + vzd_pkg::QLW'(n_push) - vzd_pkg::QLW'(do_pop);

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_q] <= step_i.r0;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_next] <= step_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      level_q <= level_d;
    end
  end

  assign head_o  = mem_q[rd_q];
  assign level_o = level_q;

endmodule

// ===== tb/sv/vzd_result_checker.sv =====
// Result checker for the varint zig-zag delta decoder: follows register writes,
// decodes every accepted byte into the results it owes and matches the output
// stream against them in order. Depends on vzd_pkg.
module vzd_result_checker
  import vzd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] in_byte
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [103:0] m_axis_tdata,   // [2:0] error_code, [66:3] element_value,
                                       // [98:67] element_index, rest zero
  input  logic [1:0]   m_axis_tuser,   // [1:0] result_kind
  input  logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  output int unsigned  mismatches_o,
  output int unsigned  owed_o
);

  logic [1:0]  cfg_size_code;
  logic [31:0] cfg_expected;
  phase_e      blk_phase;
  logic [1:0]  hdr_seen;
  logic [31:0] elem_total;
  logic [31:0] elem_done;
  logic [63:0] vint_acc;
  logic [3:0]  vint_len;
  logic [63:0] run_sum;
  result_t     owed_results[$];
  int unsigned mismatch_count = 0;

  function automatic logic [63:0] elem_mask(input logic [1:0] code);
    return (code == 2'd3) ? '1 : ((64'd1 << (8 << code)) - 64'd1);
  endfunction

  task automatic owe_result(input kind_e k, input err_e c, input logic [63:0] v,
                            input logic [31:0] idx, input logic l);
    result_t r;
    r.kind  = k;
    r.code  = c;
    r.value = v;
    r.index = idx;
    r.last  = l;
    owed_results.insert(owed_results.size(), r);
  endtask

  task automatic clear_block();
    blk_phase  = PH_HEADER;
    hdr_seen   = '0;
    elem_total = '0;
    elem_done  = '0;
    vint_acc   = '0;
    vint_len   = '0;
    run_sum    = '0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic fin);
    logic [63:0] size;
    logic [63:0] delta;
    err_e        hdr_err;
    case (blk_phase)
      PH_HEADER: begin
        elem_total = elem_total | (32'(b) << (8 * hdr_seen));
        if (hdr_seen != HDR_LAST_BYTE) begin
          hdr_seen = hdr_seen + 2'd1;
          if (fin) begin
            owe_result(KIND_ERR, ERR_SHORT_HDR, '0, '0, 1'b1);
            clear_block();
          end
        end else begin
          size    = {32'd0, elem_total} << cfg_size_code;
          hdr_err = ERR_NONE;
          if (size > {32'd0, MAX_OUTPUT_BYTES_DEF}) begin
            hdr_err = ERR_OVER_LIMIT;
          end else if (cfg_expected != '0 && {32'd0, cfg_expected} != size) begin
            hdr_err = ERR_SIZE_MISMATCH;
          end
          if (hdr_err != ERR_NONE) begin
            owe_result(KIND_ERR, hdr_err, '0, '0, 1'b1);
            blk_phase = PH_ERROR;
          end else if (elem_total == '0) begin
            blk_phase = PH_DONE;
            if (fin) owe_result(KIND_END, ERR_NONE, '0, '0, 1'b1);
          end else begin
            blk_phase = PH_BODY;
            if (fin) owe_result(KIND_ERR, ERR_TRUNCATED, '0, '0, 1'b1);
          end
          if (fin) clear_block();
        end
      end
      PH_BODY: begin
        vint_acc = vint_acc | (64'(b[6:0]) << (7 * vint_len));
        if (!b[7]) begin
          delta   = ((vint_acc >> 1) ^ {64{vint_acc[0]}}) & elem_mask(cfg_size_code);
          run_sum = (run_sum + delta) & elem_mask(cfg_size_code);
          owe_result(KIND_ELEM, ERR_NONE, run_sum, elem_done, 1'b0);
          elem_done = elem_done + 32'd1;
          vint_acc  = '0;
          vint_len  = '0;
          if (elem_done >= elem_total) blk_phase = PH_DONE;
          if (fin) begin
            if (blk_phase == PH_DONE) begin
              owe_result(KIND_END, ERR_NONE, '0, '0, 1'b1);
            end else begin
              owe_result(KIND_ERR, ERR_TRUNCATED, '0, '0, 1'b1);
            end
            clear_block();
          end
        end else begin
          vint_len = vint_len + 4'd1;
          if (vint_len >= VARINT_MAX_BYTES) begin
            owe_result(KIND_ERR, ERR_VARINT_LONG, '0, '0, 1'b1);
            blk_phase = PH_ERROR;
            if (fin) clear_block();
          end else if (fin) begin
            owe_result(KIND_ERR, ERR_TRUNCATED, '0, '0, 1'b1);
            clear_block();
          end
        end
      end
      PH_DONE: begin
        if (fin) begin
          owe_result(KIND_END, ERR_NONE, '0, '0, 1'b1);
          clear_block();
        end
      end
      default: begin
        if (fin) clear_block();
      end
    endcase
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s mismatch, got %0h want %0h", $time, field, got, want);
    mismatch_count++;
  endtask

  task automatic check_result();
    result_t want;
    if (owed_results.size() == 0) begin
      report_mismatch("unowed result kind", 64'(m_axis_tuser), '0);
    end else begin
      want = owed_results.pop_front();
      if (m_axis_tuser != want.kind)
        report_mismatch("result_kind", 64'(m_axis_tuser), 64'(want.kind));
      if (m_axis_tdata[2:0] != want.code)
        report_mismatch("error_code", 64'(m_axis_tdata[2:0]), 64'(want.code));
      if (m_axis_tdata[66:3] != want.value)
        report_mismatch("element_value", m_axis_tdata[66:3], want.value);
      if (m_axis_tdata[98:67] != want.index)
        report_mismatch("element_index", 64'(m_axis_tdata[98:67]), 64'(want.index));
      if (m_axis_tlast != want.last)
        report_mismatch("run_last", 64'(m_axis_tlast), 64'(want.last));
      if (m_axis_tdata[103:99] != '0)
        report_mismatch("tdata padding", 64'(m_axis_tdata[103:99]), '0);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_size_code = '0;
      cfg_expected  = '0;
      clear_block();
      owed_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_e'(cfg_index_i))
          REG_SIZE_CODE: cfg_size_code = cfg_data_i[1:0];
          REG_EXPECTED:  cfg_expected  = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) check_result();
    end
    owed_o       <= owed_results.size();
    mismatches_o <= mismatch_count;
  end

endmodule

// ===== tb/sv/varint_zigzag_delta_decoder_test.sv =====
// Testbench top for the varint zig-zag delta decoder: clock, reset, register
// writes, compressed-block stimulus and output back-pressure; checking is done
// by vzd_result_checker. Depends on vzd_pkg, the decoder RTL and the checker.
module varint_zigzag_delta_decoder_test;
  import vzd_pkg::*;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata  = '0;
  logic         s_axis_tlast  = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_valid_i   = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i   = '0;
  logic [31:0]  cfg_data_i    = '0;

  int unsigned  mismatches;
  int unsigned  owed;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  bytes_sent    = 0;
  logic [1:0]   cur_code      = '0;
  logic [31:0]  cur_expected  = '0;
  logic [7:0]   block_bytes[$];

  varint_zigzag_delta_decoder dut (.*);

  vzd_result_checker results_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatches),
    .owed_o       (owed)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("varint_zigzag_delta_decoder verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_block();
    int i;
    for (i = 0; i < block_bytes.size(); i++) begin
      send_byte(block_bytes[i], i == block_bytes.size() - 1);
    end
  endtask

  // hold input until every owed result has left, then let the core settle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (owed != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_e idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  function automatic logic [63:0] rand_value();
    logic [63:0] u;
    int unsigned nb;
    u  = {$urandom, $urandom};
    nb = $urandom_range(0, 64);
    if (nb < 64) u = u & ((64'd1 << nb) - 64'd1);
    return u;
  endfunction

  task automatic add_byte(input logic [7:0] b);
    block_bytes.insert(block_bytes.size(), b);
  endtask

  task automatic put_count(input logic [31:0] n);
    add_byte(n[7:0]);
    add_byte(n[15:8]);
    add_byte(n[23:16]);
    add_byte(n[31:24]);
  endtask

  // LEB128 with optional redundant groups, up to ten bytes
  task automatic put_varint(input logic [63:0] u, input int unsigned pad);
    int unsigned len;
    int unsigned i;
    logic [6:0]  g;
    len = 1;
    while (len < 10 && (u >> (7 * len)) != '0) len++;
    len = (len + pad > 10) ? 10 : len + pad;
    for (i = 0; i < len; i++) begin
      g = 7'(u >> (7 * i));
      if (i == 9) g[6:1] = 6'($urandom);
      add_byte({i != len - 1, g});
    end
  endtask

  task automatic put_overlong();
    repeat ($urandom_range(10, 12)) add_byte({1'b1, 7'($urandom)});
  endtask

  task automatic make_block();
    int unsigned shape;
    int unsigned count;
    int unsigned cut;
    int unsigned i;
    block_bytes.delete();
    shape = $urandom_range(99);
    if (cur_expected != '0 && $urandom_range(4) != 0) count = cur_expected >> cur_code;
    else count = $urandom_range(0, 10);
    if (shape < 12) begin
      if ($urandom_range(1) == 1) count = (32'd16777216 >> cur_code) + $urandom_range(0, 1);
      else count = $urandom;
      put_count(count);
      repeat ($urandom_range(0, 3)) put_varint(rand_value(), 0);
    end else if (shape < 22) begin
      put_count(count);
      for (i = 0; i < count && i < 3; i++) put_varint(rand_value(), 0);
      put_overlong();
    end else begin
      put_count(count);
      for (i = 0; i < count && i < 16; i++) begin
        put_varint(rand_value(), ($urandom_range(7) == 0) ? $urandom_range(1, 9) : 0);
      end
    end
    if (shape < 80 && $urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
    end
    if (shape >= 80 && shape < 92) begin
      cut = $urandom_range(1, block_bytes.size());
      block_bytes = block_bytes[0:cut-1];
    end else if (shape >= 92) begin
      block_bytes.delete();
      repeat ($urandom_range(1, 16)) add_byte(8'($urandom));
    end
  endtask

  task automatic run_setting(input logic [1:0] code, input logic [31:0] exp_bytes,
                             input int unsigned budget);
    int unsigned start;
    settle();
    cfg_write(REG_SIZE_CODE, {30'd0, code});
    cfg_write(REG_EXPECTED, exp_bytes);
    cfg_valid_i  <= 1'b0;
    cur_code     = code;
    cur_expected = exp_bytes;
    start        = bytes_sent;
    while (bytes_sent - start < budget) begin
      make_block();
      send_block();
    end
  endtask

  initial begin
    int unsigned ph;
    int unsigned k;
    int unsigned sel;
    logic [1:0]  code;
    logic [31:0] exp_bytes;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 8;
    recv_idle_pct = 51;

    // short header
    block_bytes = {8'h00};
    send_block();
    // count far over the size limit
    block_bytes = {8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_block();
    // empty count, trailing byte, end on the final byte
    block_bytes = {8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
    send_block();
    // ten continuation bytes in one varint
    block_bytes = {8'h01, 8'h00, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80,
                   8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'hFF};
    send_block();

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 8;
          recv_idle_pct = 51;
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (k = 0; k < 4; k++) begin
        code = (ph == 1) ? 2'(3 - k) : 2'(k);
        sel  = (k + ph) % 4;
        case (sel)
          2:       exp_bytes = 32'($urandom_range(1, 8)) << code;
          3:       exp_bytes = '1;
          default: exp_bytes = '0;
        endcase
        run_setting(code, exp_bytes, (sel == 3) ? 40 : 170);
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (owed != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && owed == 0) begin
      $display("varint_zigzag_delta_decoder verification clean");
    end else begin
      $display("varint_zigzag_delta_decoder verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/vzd_pkg.sv
hdl/vzd_core.sv
hdl/vzd_queue.sv
hdl/varint_zigzag_delta_decoder.sv
tb/sv/vzd_result_checker.sv
tb/sv/varint_zigzag_delta_decoder_test.sv
